// File: rtl/i2cm_pkg.sv
// Shared types and constants of the I2C register-access master.
// Used by the front end, the transaction engine and the top level.
package i2cm_pkg;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2,
      MODE_QUEUE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_ACK_TIMEOUT = 2'd0,
      CSR_HALF_BIT    = 2'd1,
      CSR_START_STOP  = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
   localparam logic [7:0] HALF_BIT_RESET    = 8'd2;
   localparam logic [7:0] START_STOP_RESET  = 8'd4;
   localparam int         BIT_COUNT         = 8;

   typedef enum logic [14:0] {
      PH_IDLE      = 15'b000000000000001,
      PH_START_A   = 15'b000000000000010,
      PH_START_B   = 15'b000000000000100,
      PH_TX_LOW    = 15'b000000000001000,
      PH_TX_HIGH   = 15'b000000000010000,
      PH_ACK_LOW   = 15'b000000000100000,
      PH_ACK_HIGH  = 15'b000000001000000,
      PH_ACK_POLL  = 15'b000000010000000,
      PH_RX_LOW    = 15'b000000100000000,
      PH_RX_HIGH   = 15'b000001000000000,
      PH_MACK_LOW  = 15'b000010000000000,
      PH_MACK_HIGH = 15'b000100000000000,
      PH_STOP_A    = 15'b001000000000000,
      PH_STOP_B    = 15'b010000000000000,
      PH_STOP_C    = 15'b100000000000000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_ADDR_W = 2'd0,
      KIND_REG    = 2'd1,
      KIND_ADDR_R = 2'd2,
      KIND_DATA   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] ack_timeout;
      logic [7:0] half_bit;
      logic [7:0] start_stop;
   } cfg_type;

   typedef struct packed {
      mode_type   mode;
      logic       is_begin;
      logic       sda_sample;
      logic [6:0] device_addr;
      logic [7:0] reg_addr;
      logic [7:0] read_length;
      logic [7:0] write_byte;
   } cmd_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic       error;
      logic [7:0] read_byte;
      logic       read_valid;
   } rsp_type;

endpackage

// File: rtl/i2cm_fifo.sv
// Small first-in first-out buffer in flip-flops, generic in width and depth.
// Standalone; the front end and the top level instantiate it.
module i2cm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// File: rtl/i2cm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; holds the queued write bytes of the engine.
module i2cm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
endmodule

// File: rtl/i2cm_front.sv
// Front end: accepts request words, classifies them and queues them.
// Depends on i2cm_pkg and i2cm_fifo.
module i2cm_front
   import i2cm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_mode,
   input  logic       req_sda_sample,
   input  logic [6:0] req_device_addr,
   input  logic [7:0] req_reg_addr,
   input  logic [7:0] req_read_length,
   input  logic [7:0] req_write_byte,
   output logic       cmd_valid,
   output cmd_type    cmd,
   input  logic       cmd_pop
);
   cmd_type cmd_new;
   logic    cmd_empty;
   logic [$bits(cmd_type)-1:0] cmd_bits;

   always_comb begin
      cmd_new.mode        = mode_type'(req_mode);
      cmd_new.is_begin    = (mode_type'(req_mode) == MODE_WRITE) ||
                            (mode_type'(req_mode) == MODE_READ);
      cmd_new.sda_sample  = req_sda_sample;
      cmd_new.device_addr = req_device_addr;
      cmd_new.reg_addr    = req_reg_addr;
      cmd_new.read_length = req_read_length;
      cmd_new.write_byte  = req_write_byte;
   end

   i2cm_fifo #(.WIDTH($bits(cmd_type)), .DEPTH(2)) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cmd_new),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_bits),
      .empty     (cmd_empty)
   );

   assign cmd       = cmd_bits;
   assign cmd_valid = !cmd_empty;
endmodule

// File: rtl/i2cm_engine.sv
// Transaction engine: one word per cycle through the bus state machine, while the result queue has room.
// Depends on i2cm_pkg and i2cm_ram (queued write bytes).
module i2cm_engine
   import i2cm_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp
);
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int BW = (FW > 8) ? FW : 8;

   phase_type      phase_ff, phase_in;
   kind_type       stage_ff, stage_in;
   logic [7:0]     tick_ff, tick_in;
   logic [3:0]     bit_ff, bit_in;
   logic [7:0]     shift_ff, shift_in;
   logic [7:0]     wait_ff, wait_in;
   logic [BW-1:0]  left_ff, left_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic [6:0]     taddr_ff, taddr_in;
   logic [7:0]     treg_ff, treg_in;
   logic           is_read_ff, is_read_in;
   logic           failed_ff, failed_in;
   logic           scl_ff, scl_in, sda_ff, sda_in;

   logic           item_go;
   logic           ram_we;
   logic [BW-1:0]  rd_index;
   logic [7:0]     queued_byte;

   assign item_go  = cmd_valid && !rsp_full;
   assign cmd_pop  = item_go;
   assign rsp_push = item_go;

   // The next byte to send is fetched ahead: while a data byte is on the
   // bus the address points one past it, so the byte is ready at its ack.
   assign rd_index = BW'(fill_ff) - left_ff + ((stage_ff == KIND_DATA) ? BW'(1) : BW'(0));

   i2cm_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH), .AW(AW)) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (cmd.write_byte),
      .rd_addr (rd_index[AW-1:0]),
      .rd_data (queued_byte)
   );

   always_comb begin
      logic       expired;
      logic       ack_fire;
      logic       acked;
      logic [BW-1:0] left_dec;

      phase_in   = phase_ff;
      stage_in   = stage_ff;
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      wait_in    = wait_ff;
      left_in    = left_ff;
      fill_in    = fill_ff;
      taddr_in   = taddr_ff;
      treg_in    = treg_ff;
      is_read_in = is_read_ff;
      failed_in  = failed_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      ram_we     = 1'b0;
      expired    = 1'b1;
      ack_fire   = 1'b0;
      acked      = 1'b0;
      left_dec   = left_ff;

      rsp.done_res   = 1'b0;
      rsp.error      = 1'b0;
      rsp.read_byte  = 8'd0;
      rsp.read_valid = 1'b0;

      if (item_go) begin
         if (phase_ff == PH_IDLE) begin
            if (cmd.is_begin) begin
               taddr_in   = cmd.device_addr;
               treg_in    = cmd.reg_addr;
               is_read_in = (cmd.mode == MODE_READ);
               left_in    = (cmd.mode == MODE_READ) ? BW'(cmd.read_length) : BW'(fill_ff);
               failed_in  = 1'b0;
               stage_in   = KIND_ADDR_W;
               phase_in   = PH_START_A;
               tick_in    = cfg.start_stop;
               scl_in     = 1'b1;
               sda_in     = 1'b1;
            end else if (cmd.mode == MODE_QUEUE && fill_ff < FW'(QUEUE_DEPTH)) begin
               ram_we  = 1'b1;
               fill_in = fill_ff + 1'b1;
            end
         end else if (cmd.mode == MODE_TICK) begin
            if (phase_ff != PH_ACK_POLL) begin
               if (tick_ff > 8'd1) begin
                  tick_in = tick_ff - 1'b1;
                  expired = 1'b0;
               end else begin
                  tick_in = 8'd0;
               end
            end
            if (expired) begin
               unique case (phase_ff)
                  PH_START_A: begin
                     phase_in = PH_START_B;
                     tick_in  = cfg.start_stop;
                     scl_in   = 1'b1;
                     sda_in   = 1'b0;
                  end
                  PH_START_B: begin
                     stage_in = (stage_ff == KIND_ADDR_R) ? KIND_ADDR_R : KIND_ADDR_W;
                     shift_in = {taddr_ff, (stage_ff == KIND_ADDR_R)};
                     bit_in   = 4'd0;
                     phase_in = PH_TX_LOW;
                     tick_in  = cfg.half_bit;
                     scl_in   = 1'b0;
                     sda_in   = taddr_ff[6];
                  end
                  PH_TX_LOW: begin
                     phase_in = PH_TX_HIGH;
                     tick_in  = cfg.half_bit;
                     scl_in   = 1'b1;
                  end
                  PH_TX_HIGH: begin
                     shift_in = {shift_ff[6:0], 1'b0};
                     bit_in   = bit_ff + 1'b1;
                     if (bit_in >= 4'(BIT_COUNT)) begin
                        phase_in = PH_ACK_LOW;
                        tick_in  = 8'd1;
                        scl_in   = 1'b0;
                        sda_in   = 1'b1;
                     end else begin
                        phase_in = PH_TX_LOW;
                        tick_in  = cfg.half_bit;
                        scl_in   = 1'b0;
                        sda_in   = shift_ff[6];
                     end
                  end
                  PH_ACK_LOW: begin
                     phase_in = PH_ACK_HIGH;
                     tick_in  = 8'd1;
                     scl_in   = 1'b1;
                     sda_in   = 1'b1;
                  end
                  PH_ACK_HIGH: begin
                     wait_in  = 8'd0;
                     phase_in = PH_ACK_POLL;
                     tick_in  = 8'd0;
                     scl_in   = 1'b1;
                     sda_in   = 1'b1;
                  end
                  PH_ACK_POLL: begin
                     if (!cmd.sda_sample) begin
                        ack_fire = 1'b1;
                        acked    = 1'b1;
                     end else begin
                        if (wait_ff != 8'hFF) begin
                           wait_in = wait_ff + 1'b1;
                        end
                        ack_fire = (wait_in >= cfg.ack_timeout);
                     end
                     if (ack_fire) begin
                        scl_in = 1'b0;
                        sda_in = 1'b1;
                     end
                  end
                  PH_RX_LOW: begin
                     phase_in = PH_RX_HIGH;
                     tick_in  = cfg.half_bit;
                     scl_in   = 1'b1;
                     sda_in   = 1'b1;
                  end
                  PH_RX_HIGH: begin
                     shift_in = {shift_ff[6:0], cmd.sda_sample};
                     bit_in   = bit_ff + 1'b1;
                     tick_in  = cfg.half_bit;
                     scl_in   = 1'b0;
                     if (bit_in >= 4'(BIT_COUNT)) begin
                        rsp.read_valid = 1'b1;
                        rsp.read_byte  = shift_in;
                        phase_in       = PH_MACK_LOW;
                        // Acknowledge every byte but the last one.
                        sda_in         = !(left_ff > BW'(1));
                     end else begin
                        phase_in = PH_RX_LOW;
                        sda_in   = 1'b1;
                     end
                  end
                  PH_MACK_LOW: begin
                     phase_in = PH_MACK_HIGH;
                     tick_in  = cfg.half_bit;
                     scl_in   = 1'b1;
                  end
                  PH_MACK_HIGH: begin
                     left_dec = (left_ff != '0) ? left_ff - 1'b1 : left_ff;
                     left_in  = left_dec;
                     if (left_dec == '0) begin
                        phase_in = PH_STOP_A;
                        tick_in  = cfg.start_stop;
                        scl_in   = 1'b0;
                        sda_in   = 1'b0;
                     end else begin
                        shift_in = 8'd0;
                        bit_in   = 4'd0;
                        phase_in = PH_RX_LOW;
                        tick_in  = cfg.half_bit;
                        scl_in   = 1'b0;
                        sda_in   = 1'b1;
                     end
                  end
                  PH_STOP_A: begin
                     phase_in = PH_STOP_B;
                     tick_in  = cfg.start_stop;
                     scl_in   = 1'b1;
                     sda_in   = 1'b0;
                  end
                  PH_STOP_B: begin
                     phase_in = PH_STOP_C;
                     tick_in  = cfg.start_stop;
                     scl_in   = 1'b1;
                     sda_in   = 1'b1;
                  end
                  PH_STOP_C: begin
                     rsp.done_res = 1'b1;
                     rsp.error    = failed_ff;
                     if (!is_read_ff) begin
                        fill_in = '0;
                     end
                     left_in   = '0;
                     failed_in = 1'b0;
                     phase_in  = PH_IDLE;
                     tick_in   = 8'd0;
                     scl_in    = 1'b1;
                     sda_in    = 1'b1;
                  end
                  PH_IDLE: begin
                     phase_in = PH_IDLE;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end

            // Resolution of the acknowledge window, by the kind of byte sent.
            if (ack_fire) begin
               unique case (stage_ff)
                  KIND_ADDR_W: begin
                     if (!acked) begin
                        failed_in = 1'b1;
                        phase_in  = PH_STOP_A;
                        tick_in   = cfg.start_stop;
                        scl_in    = 1'b0;
                        sda_in    = 1'b0;
                     end else begin
                        stage_in = KIND_REG;
                        shift_in = treg_ff;
                        bit_in   = 4'd0;
                        phase_in = PH_TX_LOW;
                        tick_in  = cfg.half_bit;
                        scl_in   = 1'b0;
                        sda_in   = treg_ff[7];
                     end
                  end
                  KIND_REG: begin
                     if (is_read_ff) begin
                        stage_in = KIND_ADDR_R;
                        phase_in = PH_START_A;
                        tick_in  = cfg.start_stop;
                        scl_in   = 1'b1;
                        sda_in   = 1'b1;
                     end else if (left_ff != '0) begin
                        stage_in = KIND_DATA;
                        shift_in = queued_byte;
                        bit_in   = 4'd0;
                        phase_in = PH_TX_LOW;
                        tick_in  = cfg.half_bit;
                        scl_in   = 1'b0;
                        sda_in   = queued_byte[7];
                     end else begin
                        phase_in = PH_STOP_A;
                        tick_in  = cfg.start_stop;
                        scl_in   = 1'b0;
                        sda_in   = 1'b0;
                     end
                  end
                  KIND_ADDR_R: begin
                     if (left_ff == '0) begin
                        phase_in = PH_STOP_A;
                        tick_in  = cfg.start_stop;
                        scl_in   = 1'b0;
                        sda_in   = 1'b0;
                     end else begin
                        shift_in = 8'd0;
                        bit_in   = 4'd0;
                        phase_in = PH_RX_LOW;
                        tick_in  = cfg.half_bit;
                        scl_in   = 1'b0;
                        sda_in   = 1'b1;
                     end
                  end
                  KIND_DATA: begin
                     if (!acked) begin
                        failed_in = 1'b1;
                        phase_in  = PH_STOP_A;
                        tick_in   = cfg.start_stop;
                        scl_in    = 1'b0;
                        sda_in    = 1'b0;
                     end else begin
                        left_in = left_ff - 1'b1;
                        if (left_in == '0) begin
                           phase_in = PH_STOP_A;
                           tick_in  = cfg.start_stop;
                           scl_in   = 1'b0;
                           sda_in   = 1'b0;
                        end else begin
                           shift_in = queued_byte;
                           bit_in   = 4'd0;
                           phase_in = PH_TX_LOW;
                           tick_in  = cfg.half_bit;
                           scl_in   = 1'b0;
                           sda_in   = queued_byte[7];
                        end
                     end
                  end
                  default: begin
                     stage_in = stage_ff;
                  end
               endcase
            end
         end
      end

      rsp.scl_level = scl_in;
      rsp.sda_level = sda_in;
      rsp.busy_res  = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         stage_ff   <= KIND_ADDR_W;
         tick_ff    <= '0;
         bit_ff     <= '0;
         shift_ff   <= '0;
         wait_ff    <= '0;
         left_ff    <= '0;
         fill_ff    <= '0;
         taddr_ff   <= '0;
         treg_ff    <= '0;
         is_read_ff <= 1'b0;
         failed_ff  <= 1'b0;
         scl_ff     <= 1'b1;
         sda_ff     <= 1'b1;
      end else begin
         phase_ff   <= phase_in;
         stage_ff   <= stage_in;
         tick_ff    <= tick_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         wait_ff    <= wait_in;
         left_ff    <= left_in;
         fill_ff    <= fill_in;
         taddr_ff   <= taddr_in;
         treg_ff    <= treg_in;
         is_read_ff <= is_read_in;
         failed_ff  <= failed_in;
         scl_ff     <= scl_in;
         sda_ff     <= sda_in;
      end
   end
endmodule

// File: rtl/i2c_master_register_access.sv
// I2C master for register reads and writes, advanced by one-microsecond tick words.
// Request words enter a queue-like port (req_push / req_full). Mode tick moves the
// bus state machine by one tick; begin-write and begin-read start a transaction
// while idle; queue appends one write byte to a store of QUEUE_DEPTH bytes.
// Every request word gives exactly one result word on the rsp_ port: the pin
// levels after the word, busy, a done pulse with error, and any received byte.
// Throughput is one word per clock while the result queue has room: the front
// queue holds accepted words, the engine takes one per cycle and writes its result
// into a two-entry result queue. An accepted word passes through the front queue
// and the engine into the result queue, whose registered output drives rsp_.
// When the receiver stops popping, the result queue fills, the engine halts and
// the front queue fills, so req_full rises; nothing is dropped.
// Configuration writes (csr_valid, always ready) set the timing registers and are
// meant for idle periods only. Reset empties both queues, returns the engine to
// idle with both pins released, clears the byte count and restores the timing
// registers to 250, 2 and 4. The byte store itself needs no clearing.
// Depends on i2cm_pkg, i2cm_front, i2cm_engine, i2cm_fifo and i2cm_ram.
module i2c_master_register_access
   import i2cm_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_mode,
   input  logic       req_sda_sample,
   input  logic [6:0] req_device_addr,
   input  logic [7:0] req_reg_addr,
   input  logic [7:0] req_read_length,
   input  logic [7:0] req_write_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic       rsp_error,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_read_valid,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);
   cfg_type cfg_ff, cfg_in;
   logic    cmd_valid, cmd_pop;
   cmd_type cmd;
   logic    rsp_full, rsp_push;
   rsp_type rsp_new, rsp_out;
   logic [$bits(rsp_type)-1:0] rsp_bits;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ACK_TIMEOUT: cfg_in.ack_timeout = csr_data;
            CSR_HALF_BIT:    cfg_in.half_bit    = csr_data;
            CSR_START_STOP:  cfg_in.start_stop  = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ack_timeout <= ACK_TIMEOUT_RESET;
         cfg_ff.half_bit    <= HALF_BIT_RESET;
         cfg_ff.start_stop  <= START_STOP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   i2cm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_mode        (req_mode),
      .req_sda_sample  (req_sda_sample),
      .req_device_addr (req_device_addr),
      .req_reg_addr    (req_reg_addr),
      .req_read_length (req_read_length),
      .req_write_byte  (req_write_byte),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   i2cm_engine #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_new)
   );

   i2cm_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(2)) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_new),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty)
   );

   assign rsp_out        = rsp_bits;
   assign rsp_scl_level  = rsp_out.scl_level;
   assign rsp_sda_level  = rsp_out.sda_level;
   assign rsp_busy_res   = rsp_out.busy_res;
   assign rsp_done_res   = rsp_out.done_res;
   assign rsp_error      = rsp_out.error;
   assign rsp_read_byte  = rsp_out.read_byte;
   assign rsp_read_valid = rsp_out.read_valid;
endmodule

// File: rtl/i2cm_checker.sv
// Port-level checker of the I2C register-access master, bound to its top level.
// Depends on nothing but the top level's ports.
module i2cm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_scl_level,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic       rsp_error,
   input logic [7:0] rsp_read_byte,
   input logic       rsp_read_valid
);
   // Reset leaves no stale result behind.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // A transaction that ends has left the busy state in the same word.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_done_res) |-> !rsp_busy_res)
      else $error("done reported while still busy");

   // An error flag only ever comes with the done pulse.
   a_error_done: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_error) |-> rsp_done_res)
      else $error("error reported without done");

   // A received byte completes at the falling clock edge before the master ack.
   a_read_low: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_read_valid) |-> (rsp_busy_res && !rsp_scl_level))
      else $error("received byte outside a busy low clock phase");

   // A stalled result word stays put (checked on its received byte).
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_read_byte)))
      else $error("result word changed while stalled");
endmodule

bind i2c_master_register_access i2cm_checker u_i2cm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_scl_level  (rsp_scl_level),
   .rsp_busy_res   (rsp_busy_res),
   .rsp_done_res   (rsp_done_res),
   .rsp_error      (rsp_error),
   .rsp_read_byte  (rsp_read_byte),
   .rsp_read_valid (rsp_read_valid)
);
